/* rtl/fpfa_pkg.sv */
// fpfa_pkg: command and status codes and fixed field widths of the
// fixed partition fit allocator; no dependencies
`default_nettype none

package fpfa_pkg;

  localparam int CMD_W         = 2;
  localparam int ITEM_SIZE_W   = 32;
  localparam int BLOCK_INDEX_W = 6;
  localparam int STATUS_W      = 2;
  localparam int OUT_TDATA_W   = 16;

  // command codes carried in tuser
  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FIT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

  localparam logic [1:0] POLICY_FIRST_FIT = 2'd0;

endpackage

`default_nettype wire

/* rtl/fixed_partition_fit_allocator.sv */
// fixed_partition_fit_allocator: one item at a time, one result per item.
// A request walks the loaded partitions one per cycle through the memory read
// port, a release rewrites one taken mark per cycle, load and clear need no walk.
// The next input can transfer in the cycle the last result is first offered; a
// stalled result holds input. Reset empties the table and selects first fit;
// memories are not cleared.
`default_nettype none

module fixed_partition_fit_allocator #(
  parameter int MAX_PARTITIONS = 64,
  parameter int SIZE_BITS      = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic                              cfg_wr_data,   // fit_policy
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [fpfa_pkg::ITEM_SIZE_W-1:0]  in_tdata,      // [31:0] item_size
  input  wire logic [fpfa_pkg::CMD_W-1:0]        in_tuser,      // [1:0] cmd
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [fpfa_pkg::OUT_TDATA_W-1:0]  out_tdata      // [0] granted,
                                                                // [6:1] block_index,
                                                                // [8:7] status, rest 0
);

  localparam int IDX_W = $clog2(MAX_PARTITIONS);
  localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
  localparam int BIW   = fpfa_pkg::BLOCK_INDEX_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic                    policy_r, policy_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        sweep_r, sweep_nxt;
  logic                    res_granted_r, res_granted_nxt;
  logic [BIW-1:0]          res_index_r, res_index_nxt;
  logic [fpfa_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [fpfa_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                    in_xfer;
  logic                    out_free;
  logic [SIZE_BITS+fpfa_pkg::ITEM_SIZE_W-1:0] size_ext;
  logic [SIZE_BITS-1:0]    item_sz;
  logic [IDX_W+BIW-1:0]    count_idx_ext;
  logic [IDX_W+BIW-1:0]    pick_idx_ext;

  logic                    size_we;
  logic                    taken_we;
  logic [IDX_W-1:0]        taken_waddr;
  logic                    taken_wdata;
  logic [IDX_W-1:0]        rd_addr;
  logic [SIZE_BITS-1:0]    rd_size;
  logic                    rd_taken;
  logic                    scan_start;
  logic                    scan_done;
  logic                    scan_found;
  logic [IDX_W-1:0]        scan_pick;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // size masked to the stored width, indexes fitted to the 6-bit field
  assign size_ext      = {{SIZE_BITS{1'b0}}, in_tdata};
  assign item_sz       = size_ext[SIZE_BITS-1:0];
  assign count_idx_ext = {{BIW{1'b0}}, count_r[IDX_W-1:0]};
  assign pick_idx_ext  = {{BIW{1'b0}}, scan_pick};

  assign scan_start = in_xfer && (in_tuser == fpfa_pkg::CMD_REQUEST);
  assign size_we    = in_xfer && (in_tuser == fpfa_pkg::CMD_LOAD)
                      && (count_r != CNT_W'(MAX_PARTITIONS));

  // taken mark writes: cleared on load and sweep, set on grant
  always_comb begin
    taken_we    = 1'b0;
    taken_waddr = count_r[IDX_W-1:0];
    taken_wdata = 1'b0;
    if (size_we) begin
      taken_we = 1'b1;
    end else if (state_r == ST_SCAN && scan_done && scan_found) begin
      taken_we    = 1'b1;
      taken_waddr = scan_pick;
      taken_wdata = 1'b1;
    end else if (state_r == ST_SWEEP && sweep_r != count_r) begin
      taken_we    = 1'b1;
      taken_waddr = sweep_r[IDX_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    policy_nxt      = policy_r;
    count_nxt       = count_r;
    sweep_nxt       = sweep_r;
    res_granted_nxt = res_granted_r;
    res_index_nxt   = res_index_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    if (cfg_wr_en) begin
      policy_nxt = cfg_wr_data;
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          res_granted_nxt = 1'b0;
          res_index_nxt   = '0;
          res_status_nxt  = fpfa_pkg::STATUS_OK;
          state_nxt       = ST_DONE;
          case (in_tuser)
            fpfa_pkg::CMD_LOAD: begin
              if (size_we) begin
                res_index_nxt = count_idx_ext[BIW-1:0];
                count_nxt     = count_r + 1'b1;
              end else begin
                res_status_nxt = fpfa_pkg::STATUS_FULL;
              end
            end
            fpfa_pkg::CMD_REQUEST: begin
              state_nxt = ST_SCAN;
            end
            fpfa_pkg::CMD_RELEASE: begin
              sweep_nxt = '0;
              state_nxt = ST_SWEEP;
            end
            default: begin
              count_nxt = '0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          res_granted_nxt = scan_found;
          res_index_nxt   = scan_found ? pick_idx_ext[BIW-1:0] : '0;
          res_status_nxt  = scan_found ? fpfa_pkg::STATUS_OK : fpfa_pkg::STATUS_NO_FIT;
          state_nxt       = ST_DONE;
        end
      end
      ST_SWEEP: begin
        if (sweep_r == count_r) begin
          state_nxt = ST_DONE;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = fpfa_pkg::OUT_TDATA_W'({res_status_r, res_index_r, res_granted_r});
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      policy_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      policy_r    <= policy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    sweep_r       <= sweep_nxt;
    res_granted_r <= res_granted_nxt;
    res_index_r   <= res_index_nxt;
    res_status_r  <= res_status_nxt;
    out_data_r    <= out_data_nxt;
  end

  fpfa_mem #(
    .DEPTH     (MAX_PARTITIONS),
    .SIZE_BITS (SIZE_BITS)
  ) u_mem (
    .clk         (clk),
    .size_we     (size_we),
    .size_waddr  (count_r[IDX_W-1:0]),
    .size_wdata  (item_sz),
    .taken_we    (taken_we),
    .taken_waddr (taken_waddr),
    .taken_wdata (taken_wdata),
    .rd_addr     (rd_addr),
    .rd_size     (rd_size),
    .rd_taken    (rd_taken)
  );

  fpfa_scan #(
    .DEPTH     (MAX_PARTITIONS),
    .SIZE_BITS (SIZE_BITS)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (scan_start),
    .policy   (policy_r != fpfa_pkg::POLICY_FIRST_FIT[0]),
    .req_size (item_sz),
    .count    (count_r),
    .rd_addr  (rd_addr),
    .rd_size  (rd_size),
    .rd_taken (rd_taken),
    .done     (scan_done),
    .found    (scan_found),
    .pick     (scan_pick)
  );

endmodule

`default_nettype wire

/* rtl/fpfa_mem.sv */
// fpfa_mem: partition size memory and taken mark memory, one write port
// each and a shared registered read port; no dependencies
`default_nettype none

module fpfa_mem #(
  parameter int DEPTH     = 64,
  parameter int SIZE_BITS = 32,
  parameter int IDX_W     = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 size_we,
  input  wire logic [IDX_W-1:0]     size_waddr,
  input  wire logic [SIZE_BITS-1:0] size_wdata,
  input  wire logic                 taken_we,
  input  wire logic [IDX_W-1:0]     taken_waddr,
  input  wire logic                 taken_wdata,
  input  wire logic [IDX_W-1:0]     rd_addr,
  output logic      [SIZE_BITS-1:0] rd_size,
  output logic                      rd_taken
);

  logic [SIZE_BITS-1:0] size_mem [DEPTH];
  logic                 taken_mem [DEPTH];

  // size memory
  always_ff @(posedge clk) begin
    if (size_we) begin
      size_mem[size_waddr] <= size_wdata;
    end
    rd_size <= size_mem[rd_addr];
  end

  // taken mark memory
  always_ff @(posedge clk) begin
    if (taken_we) begin
      taken_mem[taken_waddr] <= taken_wdata;
    end
    rd_taken <= taken_mem[rd_addr];
  end

endmodule

`default_nettype wire

/* rtl/fpfa_scan.sv */
// fpfa_scan: walks the loaded partitions one per cycle through the
// registered memory read port and keeps the first or best fitting one
`default_nettype none

module fpfa_scan #(
  parameter int DEPTH     = 64,
  parameter int SIZE_BITS = 32,
  parameter int IDX_W     = $clog2(DEPTH),
  parameter int CNT_W     = $clog2(DEPTH + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 policy,
  input  wire logic [SIZE_BITS-1:0] req_size,
  input  wire logic [CNT_W-1:0]     count,
  output logic      [IDX_W-1:0]     rd_addr,
  input  wire logic [SIZE_BITS-1:0] rd_size,
  input  wire logic                 rd_taken,
  output logic                      done,
  output logic                      found,
  output logic      [IDX_W-1:0]     pick
);

  logic                 busy_r, busy_nxt;
  logic [CNT_W-1:0]     addr_r, addr_nxt;
  logic                 chk_r, chk_nxt;
  logic [IDX_W-1:0]     chk_idx_r, chk_idx_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     pick_r, pick_nxt;
  logic [SIZE_BITS-1:0] best_r, best_nxt;
  logic [SIZE_BITS-1:0] req_r, req_nxt;
  logic                 policy_r, policy_nxt;
  logic                 issue;
  logic                 fits;
  logic                 take;

  // read issue and compare of the entry whose read was issued in the previous cycle
  assign issue   = busy_r && (addr_r != count);
  assign rd_addr = addr_r[IDX_W-1:0];
  assign fits    = chk_r && !rd_taken && (rd_size >= req_r);
  assign take    = fits && (!found_r || (policy_r && (rd_size < best_r)));
  assign done    = busy_r && !issue && !chk_r;
  assign found   = found_r;
  assign pick    = pick_r;

  always_comb begin
    busy_nxt    = busy_r;
    addr_nxt    = addr_r;
    chk_nxt     = issue;
    chk_idx_nxt = addr_r[IDX_W-1:0];
    found_nxt   = found_r;
    pick_nxt    = pick_r;
    best_nxt    = best_r;
    req_nxt     = req_r;
    policy_nxt  = policy_r;
    if (start) begin
      busy_nxt   = 1'b1;
      addr_nxt   = '0;
      chk_nxt    = 1'b0;
      found_nxt  = 1'b0;
      req_nxt    = req_size;
      policy_nxt = policy;
    end else begin
      if (issue) begin
        addr_nxt = addr_r + 1'b1;
      end
      if (take) begin
        found_nxt = 1'b1;
        pick_nxt  = chk_idx_r;
        best_nxt  = rd_size;
      end
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      chk_r   <= 1'b0;
      found_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      chk_r   <= chk_nxt;
      found_r <= found_nxt;
    end
  end

  // scan payload
  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    chk_idx_r <= chk_idx_nxt;
    pick_r    <= pick_nxt;
    best_r    <= best_nxt;
    req_r     <= req_nxt;
    policy_r  <= policy_nxt;
  end

endmodule

`default_nettype wire

/* bench/tb.sv */
// tb: self-checking bench for fixed_partition_fit_allocator; drives load, request,
// release and clear transfers under both fit policies and checks every result
// against a partition table tracked here; depends on fpfa_pkg and the allocator rtl
`default_nettype none

typedef enum bit {FIRST_FIT = 1'b0, BEST_FIT = 1'b1} fit_policy_t;

// one result as packed in out_tdata, granted in bit 0
typedef struct packed {
  logic [6:0] pad;
  logic [1:0] status;
  logic [5:0] block_index;
  logic       granted;
} alloc_result_t;

// partition table tracker and expected-result checker
class allocation_scoreboard;
  localparam int TABLE_DEPTH = 64;

  logic [31:0]   part_size [TABLE_DEPTH];
  bit            part_taken [TABLE_DEPTH];
  int            part_count;
  fit_policy_t   policy;
  alloc_result_t expected_results[$];
  int            errors;
  int            results_seen;
  int            grants;
  int            no_fits;
  int            full_loads;

  function new();
    part_count = 0;
    policy     = FIRST_FIT;
    foreach (part_taken[i]) part_taken[i] = 1'b0;
  endfunction

  function void set_policy(fit_policy_t p);
    policy = p;
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  // apply one accepted command to the table and queue its result
  function void note_item(logic [1:0] cmd, logic [31:0] sz);
    alloc_result_t r;
    int            pick;
    r = '0;
    case (cmd)
      fpfa_pkg::CMD_LOAD: begin
        if (part_count >= TABLE_DEPTH) begin
          r.status = fpfa_pkg::STATUS_FULL;
        end else begin
          part_size[part_count]  = sz;
          part_taken[part_count] = 1'b0;
          r.block_index          = 6'(part_count);
          r.status               = fpfa_pkg::STATUS_OK;
          part_count++;
        end
      end
      fpfa_pkg::CMD_REQUEST: begin
        pick = -1;
        // first fit stops at the first free fitting entry, best fit keeps the smallest
        for (int j = 0; j < part_count && !(pick >= 0 && policy == FIRST_FIT); j++) begin
          if (!part_taken[j] && part_size[j] >= sz) begin
            if (pick < 0 || part_size[j] < part_size[pick]) pick = j;
          end
        end
        if (pick >= 0) begin
          part_taken[pick] = 1'b1;
          r.granted        = 1'b1;
          r.block_index    = 6'(pick);
          r.status         = fpfa_pkg::STATUS_OK;
        end else begin
          r.status = fpfa_pkg::STATUS_NO_FIT;
        end
      end
      fpfa_pkg::CMD_RELEASE: begin
        foreach (part_taken[i]) part_taken[i] = 1'b0;
      end
      default: begin
        foreach (part_taken[i]) part_taken[i] = 1'b0;
        part_count = 0;
      end
    endcase
    expected_results.push_back(r);
  endfunction

  function void compare_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, act);
      errors++;
    end
  endfunction

  // compare one result transfer with the oldest expectation
  function void check_result(logic [15:0] tdata);
    alloc_result_t act;
    alloc_result_t exp;
    act = alloc_result_t'(tdata);
    if (expected_results.size() == 0) begin
      $display("%0t: result with nothing expected, expected none, got %h", $time, tdata);
      errors++;
      return;
    end
    exp = expected_results.pop_front();
    results_seen++;
    if (exp.granted) grants++;
    if (exp.status == fpfa_pkg::STATUS_NO_FIT) no_fits++;
    if (exp.status == fpfa_pkg::STATUS_FULL) full_loads++;
    compare_field("granted", exp.granted, act.granted);
    compare_field("block_index", exp.block_index, act.block_index);
    compare_field("status", exp.status, act.status);
    compare_field("tdata padding", exp.pad, act.pad);
  endfunction
endclass

module tb;

  localparam int TOTAL_ITEMS  = 2000;
  localparam int PHASES       = 8;
  localparam int HOLD_CYCLES  = 500;
  localparam int LIMIT_CYCLES = 1000000;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata    = '0;
  logic [1:0]  in_tuser    = '0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;

  allocation_scoreboard sb = new();

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int items_sent   = 0;
  int cycles       = 0;
  int hold_left    = 0;
  bit hold_armed   = 1'b0;
  bit hold_done    = 1'b0;

  fixed_partition_fit_allocator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),    // [31:0] item_size
    .in_tuser    (in_tuser),    // [1:0] cmd
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)    // [0] granted, [6:1] block_index, [8:7] status
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles, sb.pending());
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: check each transfer, then pick next ready (one long hold-off once)
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_armed && !hold_done) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= !(rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // one input transfer with an optional idle gap in front
  task automatic send_item(input logic [1:0] cmd, input logic [31:0] sz);
    int gap;
    gap = 0;
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= sz;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(cmd, sz);
    items_sent++;
  endtask

  // stop offering and wait until every expected result is in
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_policy(input fit_policy_t p);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= p;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_policy(p);
  endtask

  // sizes cluster on a coarse grid so ties and exact fits are common
  function automatic logic [31:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 32'($urandom_range(0, 8) * 8);
    if (r < 80) return 32'($urandom_range(0, 255));
    if (r < 90) return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
    return $urandom;
  endfunction

  // often clear, load or overfill, then mostly requests; some releases, loads, noise
  task automatic run_episode(input bit fill_up);
    int         n_load;
    int         n_ops;
    int         r;
    logic [1:0] c;
    if ($urandom_range(0, 9) != 0) send_item(fpfa_pkg::CMD_CLEAR, $urandom);
    if (fill_up || $urandom_range(0, 9) == 0) n_load = 64 + $urandom_range(1, 3);
    else if ($urandom_range(0, 4) == 0) n_load = $urandom_range(21, 63);
    else n_load = $urandom_range(1, 20);
    for (int i = 0; i < n_load; i++) send_item(fpfa_pkg::CMD_LOAD, pick_size());
    n_ops = $urandom_range(4, 40);
    for (int i = 0; i < n_ops; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_item(fpfa_pkg::CMD_REQUEST, pick_size());
      end else if (r < 80) begin
        send_item(fpfa_pkg::CMD_RELEASE, $urandom);
      end else if (r < 90) begin
        send_item(fpfa_pkg::CMD_LOAD, pick_size());
      end else begin
        c = 2'($urandom_range(0, 3));
        send_item(c, $urandom);
      end
    end
    if ($urandom_range(0, 7) == 0) wait_drained();
  endtask

  initial begin
    int phase_items;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_policy(FIRST_FIT);

    // directed: empty table, extreme sizes, zero-size request, first fit order
    send_item(fpfa_pkg::CMD_CLEAR, 32'h0);
    send_item(fpfa_pkg::CMD_REQUEST, 32'h0);
    send_item(fpfa_pkg::CMD_RELEASE, 32'hFFFF_FFFF);
    send_item(fpfa_pkg::CMD_LOAD, 32'hFFFF_FFFF);
    send_item(fpfa_pkg::CMD_LOAD, 32'd100);
    send_item(fpfa_pkg::CMD_LOAD, 32'd0);
    send_item(fpfa_pkg::CMD_LOAD, 32'd50);
    send_item(fpfa_pkg::CMD_LOAD, 32'd100);
    send_item(fpfa_pkg::CMD_REQUEST, 32'd0);
    send_item(fpfa_pkg::CMD_REQUEST, 32'hFFFF_FFFF);
    send_item(fpfa_pkg::CMD_REQUEST, 32'd60);
    send_item(fpfa_pkg::CMD_REQUEST, 32'd0);
    send_item(fpfa_pkg::CMD_REQUEST, 32'd101);
    send_item(fpfa_pkg::CMD_RELEASE, 32'd0);
    wait_drained();

    // directed: best fit with a size tie, exhausting zero-size requests
    write_policy(BEST_FIT);
    send_item(fpfa_pkg::CMD_REQUEST, 32'd60);
    send_item(fpfa_pkg::CMD_REQUEST, 32'd60);
    send_item(fpfa_pkg::CMD_REQUEST, 32'd60);
    send_item(fpfa_pkg::CMD_REQUEST, 32'd0);
    send_item(fpfa_pkg::CMD_REQUEST, 32'd0);
    send_item(fpfa_pkg::CMD_REQUEST, 32'd0);
    send_item(fpfa_pkg::CMD_RELEASE, 32'd0);
    send_item(fpfa_pkg::CMD_REQUEST, 32'hFFFF_FFFF);
    send_item(fpfa_pkg::CMD_CLEAR, 32'hFFFF_FFFF);
    send_item(fpfa_pkg::CMD_REQUEST, 32'd1);

    // random phases: every idling mode under both policies
    phase_items = (TOTAL_ITEMS - items_sent) / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_policy(fit_policy_t'((p + p / 4) % 2));
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 79; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 79; end
        default: begin tx_idle_pct = 19; rx_stall_pct = 19; end
      endcase
      // long receiver hold-off while the sender keeps going
      if (p == 0) hold_armed = 1'b1;
      run_episode(p == 0);
      while (items_sent < TOTAL_ITEMS - (PHASES - 1 - p) * phase_items) run_episode(1'b0);
    end

    wait_drained();
    repeat (80) @(posedge clk);
    $display("covered %0d transfers in, %0d results: %0d grants, %0d no fit, %0d full table",
             items_sent, sb.results_seen, sb.grants, sb.no_fits, sb.full_loads);
    $display("both fit policies under all idling modes, one long output hold-off");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
